>>> design/crb_pkg.sv
// crb_pkg: shared types, codes, sizes, reset values and the store rewrite
// function for the configuration register block; used by every module
`default_nettype none

package crb_pkg;

   localparam int RX_DEPTH  = 16;
   localparam int RX_PTR_W  = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
   localparam int RX_CNT_W  = $clog2(RX_DEPTH + 1);
   localparam int NUM_WREGS = 22;
   localparam int SEL_W     = 5;
   localparam int WORD_W    = 32;
   localparam int BYTE_W    = 8;

   localparam logic [SEL_W-1:0] SEL_NUM       = 5'd11;
   localparam logic [SEL_W-1:0] SEL_TIMER     = 5'd16;
   localparam logic [SEL_W-1:0] SEL_IO_SIMU   = 5'd17;
   localparam logic [SEL_W-1:0] SEL_VUART     = 5'd18;
   localparam logic [SEL_W-1:0] SEL_SIMU_FLAG = 5'd19;
   localparam logic [SEL_W-1:0] SEL_TRACE     = 5'd20;
   localparam logic [SEL_W-1:0] SEL_MONITOR   = 5'd21;
   localparam logic [SEL_W-1:0] SEL_STATUS    = 5'd22;
   localparam logic [SEL_W-1:0] SEL_RX        = 5'd23;
   localparam logic [SEL_W-1:0] SEL_TX        = 5'd24;
   localparam logic [SEL_W-1:0] SEL_LED       = 5'd8;
   localparam logic [SEL_W-1:0] SEL_SWITCH    = 5'd12;
   localparam logic [SEL_W-1:0] SEL_SW_INTER  = 5'd15;

   localparam logic [WORD_W-1:0] TX_BYTE_MASK = 32'h0000_00ff;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_LOAD  = 2'd1,
      CMD_STORE = 2'd2,
      CMD_PUSH  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_UNKNOWN = 3'd1,
      ST_RO      = 3'd2,
      ST_TX_MASK = 3'd3,
      ST_RX_FULL = 3'd4
   } status_type;

   typedef struct packed {
      logic              vu_written;
      logic [BYTE_W-1:0] vu_byte;
      logic [WORD_W-1:0] number;
      logic              trace;
      logic              monitor;
   } ctx_type;

   typedef struct packed {
      logic              tick;
      logic              store;
      logic [SEL_W-1:0]  idx;
      logic [WORD_W-1:0] wdata;
   } wreg_ctrl_type;

   typedef struct packed {
      logic              push;
      logic              pop;
      logic [BYTE_W-1:0] wbyte;
   } rxq_ctrl_type;

   typedef struct packed {
      logic              empty;
      logic              one;
      logic              full;
      logic [BYTE_W-1:0] front;
   } rxq_stat_type;

   function automatic logic [WORD_W-1:0] wreg_reset(input logic [SEL_W-1:0] idx);
      logic [WORD_W-1:0] v;
      v = '0;
      case (idx)
         SEL_LED:       v = 32'h0000_ffff;
         SEL_SWITCH:    v = 32'h0000_00ff;
         SEL_SW_INTER:  v = 32'h0000_aaaa;
         SEL_SIMU_FLAG: v = 32'hffff_ffff;
         SEL_TRACE:     v = 32'h0000_0001;
         SEL_MONITOR:   v = 32'h0000_0001;
         default:       v = '0;
      endcase
      return v;
   endfunction

   function automatic logic [WORD_W-1:0] store_xform(input logic [SEL_W-1:0] idx,
                                                     input logic [WORD_W-1:0] d);
      logic [WORD_W-1:0] v;
      v = d;
      case (idx)
         SEL_VUART:     v = d & 32'h0000_00ff;
         SEL_SIMU_FLAG: v = 32'hffff_ffff;
         SEL_IO_SIMU:   v = {d[15:0], d[31:16]};
         SEL_TRACE:     v = {31'd0, (d != '0)};
         SEL_MONITOR:   v = {31'd0, d[0]};
         default:       v = d;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

>>> design/crb_rxq.sv
// crb_rxq: receive byte queue, circular buffer with head pointer and fill count
// depends on crb_pkg
`default_nettype none

module crb_rxq (
   input  wire                   clock,
   input  wire                   reset,
   input  crb_pkg::rxq_ctrl_type ctrl,
   output crb_pkg::rxq_stat_type stat
);

   localparam int SUM_W = crb_pkg::RX_CNT_W + 1;
   localparam logic [crb_pkg::RX_CNT_W-1:0] RX_CNT_ONE = crb_pkg::RX_CNT_W'(1);

   logic [crb_pkg::BYTE_W-1:0]   mem_ff [crb_pkg::RX_DEPTH];
   logic [crb_pkg::RX_PTR_W-1:0] head_ff, head_in;
   logic [crb_pkg::RX_CNT_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0]             tail_sum, tail_wrap;
   logic [crb_pkg::RX_PTR_W-1:0] tail;

   always_comb begin
      tail_sum  = SUM_W'(head_ff) + SUM_W'(count_ff);
      tail_wrap = (tail_sum >= SUM_W'(crb_pkg::RX_DEPTH)) ?
                  tail_sum - SUM_W'(crb_pkg::RX_DEPTH) : tail_sum;
      tail      = tail_wrap[crb_pkg::RX_PTR_W-1:0];
   end

   always_comb begin
      stat.empty = (count_ff == '0);
      stat.one   = (count_ff == RX_CNT_ONE);
      stat.full  = (count_ff == crb_pkg::RX_CNT_W'(crb_pkg::RX_DEPTH));
      stat.front = mem_ff[head_ff];
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (ctrl.pop && !stat.empty) begin
         head_in  = (head_ff == crb_pkg::RX_PTR_W'(crb_pkg::RX_DEPTH - 1)) ?
                    '0 : head_ff + 1'b1;
         count_in = count_ff - 1'b1;
      end else if (ctrl.push && !stat.full) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.push && !stat.full) begin
         mem_ff[tail] <= ctrl.wbyte;
      end
   end

`ifndef SYNTH
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= crb_pkg::RX_CNT_W'(crb_pkg::RX_DEPTH))
      else $error("rx count beyond depth");
   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      ctrl.push && !ctrl.pop && stat.full |=> $stable(count_ff) && $stable(head_ff))
      else $error("push into full queue changed it");
   a_pop_moves: assert property (@(posedge clock) disable iff (reset)
      ctrl.pop && !stat.empty |=> count_ff == $past(count_ff) - 1'b1)
      else $error("pop did not drop count");
`endif

endmodule

`default_nettype wire

>>> design/crb_wregs.sv
// crb_wregs: the word registers, their pending stores and the tick timer
// depends on crb_pkg
`default_nettype none

module crb_wregs (
   input  wire                           clock,
   input  wire                           reset,
   input  crb_pkg::wreg_ctrl_type        ctrl,
   output logic [crb_pkg::WORD_W-1:0]    rd_data
);

   logic [crb_pkg::WORD_W-1:0] word_regs_ff [crb_pkg::NUM_WREGS];
   logic [crb_pkg::WORD_W-1:0] word_regs_in [crb_pkg::NUM_WREGS];
   logic [crb_pkg::WORD_W-1:0] pend_vals_ff [crb_pkg::NUM_WREGS];
   logic [crb_pkg::NUM_WREGS-1:0] pend_flags_ff, pend_flags_in;
   logic [crb_pkg::WORD_W-1:0] store_val;

   assign store_val = crb_pkg::store_xform(ctrl.idx, ctrl.wdata);

   always_comb begin
      rd_data = '0;
      if (ctrl.idx < crb_pkg::SEL_W'(crb_pkg::NUM_WREGS)) begin
         rd_data = word_regs_ff[ctrl.idx];
      end
   end

   // tick commits pending words, then the timer counts on top of any commit
   always_comb begin
      pend_flags_in = pend_flags_ff;
      for (int i = 0; i < crb_pkg::NUM_WREGS; i++) begin
         word_regs_in[i] = (ctrl.tick && pend_flags_ff[i]) ? pend_vals_ff[i] : word_regs_ff[i];
         if (ctrl.tick && (crb_pkg::SEL_W'(i) == crb_pkg::SEL_TIMER)) begin
            word_regs_in[i] = word_regs_in[i] + 1'b1;
         end
      end
      if (ctrl.tick) begin
         pend_flags_in = '0;
      end else if (ctrl.store && ctrl.idx < crb_pkg::SEL_W'(crb_pkg::NUM_WREGS)) begin
         pend_flags_in[ctrl.idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_flags_ff <= '0;
         for (int i = 0; i < crb_pkg::NUM_WREGS; i++) begin
            word_regs_ff[i] <= crb_pkg::wreg_reset(crb_pkg::SEL_W'(i));
         end
      end else begin
         pend_flags_ff <= pend_flags_in;
         for (int i = 0; i < crb_pkg::NUM_WREGS; i++) begin
            word_regs_ff[i] <= word_regs_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.store && ctrl.idx < crb_pkg::SEL_W'(crb_pkg::NUM_WREGS)) begin
         pend_vals_ff[ctrl.idx] <= store_val;
      end
   end

`ifndef SYNTH
   a_tick_clears: assert property (@(posedge clock) disable iff (reset)
      ctrl.tick |=> pend_flags_ff == '0)
      else $error("pending flags survive a tick");
   a_timer_counts: assert property (@(posedge clock) disable iff (reset)
      ctrl.tick && !pend_flags_ff[crb_pkg::SEL_TIMER]
      |=> word_regs_ff[crb_pkg::SEL_TIMER] == $past(word_regs_ff[crb_pkg::SEL_TIMER]) + 1'b1)
      else $error("timer did not advance");
   a_store_defers: assert property (@(posedge clock) disable iff (reset)
      !ctrl.tick |=> word_regs_ff[crb_pkg::SEL_NUM] == $past(word_regs_ff[crb_pkg::SEL_NUM]))
      else $error("word changed outside a tick");
`endif

endmodule

`default_nettype wire

>>> design/config_register_block_with_uart.sv
// config_register_block_with_uart: top level, command decode, contexts, transmit
// byte and result register; uses crb_pkg, crb_wregs and crb_rxq
// a word's result is in the result register in the cycle after acceptance
// throughput: one word per cycle; req_ready drops only while a result is stalled
// reset: synchronous, clears control, queue pointers, contexts and restores the
// listed word register values; no clearing pass
`default_nettype none

module config_register_block_with_uart (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [1:0]  req_cmd,
   input  wire  [4:0]  req_reg_sel,
   input  wire  [31:0] req_write_data,
   input  wire  [31:0] req_write_mask,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [31:0] rsp_read_data,
   output logic [2:0]  rsp_status,
   output logic        rsp_tx_valid,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_vuart_valid,
   output logic [7:0]  rsp_vuart_byte,
   output logic [31:0] rsp_num_display,
   output logic        rsp_trace_enable,
   output logic        rsp_num_monitor_enable
);

   logic                   accept;
   crb_pkg::cmd_type       cmd;
   crb_pkg::wreg_ctrl_type wctrl;
   crb_pkg::rxq_ctrl_type  rctrl;
   crb_pkg::rxq_stat_type  rstat;
   logic [31:0]            wreg_rd;

   logic rx_avail_ff, rx_avail_in;
   logic rx_fetched_ff, rx_fetched_in;
   logic tx_pending_ff, tx_pending_in;
   logic [7:0] tx_hold_ff, tx_hold_in;
   crb_pkg::ctx_type live_ff, live_in, snap_ff, snap_in;

   logic [31:0]            rd;
   crb_pkg::status_type    st;
   logic                   txv;
   logic [7:0]             txb;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [31:0]            read_data_ff;
   crb_pkg::status_type    status_ff;
   logic                   tx_valid_ff;
   logic [7:0]             tx_byte_ff;
   crb_pkg::ctx_type       out_ctx_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign cmd       = crb_pkg::cmd_type'(req_cmd);

   crb_wregs u_wregs (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (wctrl),
      .rd_data (wreg_rd)
   );

   crb_rxq u_rxq (
      .clock (clock),
      .reset (reset),
      .ctrl  (rctrl),
      .stat  (rstat)
   );

   always_comb begin
      wctrl.tick  = 1'b0;
      wctrl.store = 1'b0;
      wctrl.idx   = req_reg_sel;
      wctrl.wdata = req_write_data;
      rctrl.push  = 1'b0;
      rctrl.pop   = 1'b0;
      rctrl.wbyte = req_write_data[7:0];
      rd            = '0;
      st            = crb_pkg::ST_OK;
      txv           = 1'b0;
      txb           = '0;
      rx_avail_in   = rx_avail_ff;
      rx_fetched_in = rx_fetched_ff;
      tx_pending_in = tx_pending_ff;
      tx_hold_in    = tx_hold_ff;
      live_in       = live_ff;
      snap_in       = snap_ff;
      unique case (cmd)
         crb_pkg::CMD_TICK: begin
            wctrl.tick    = accept;
            rctrl.pop     = accept && rx_fetched_ff;
            txv           = tx_pending_ff;
            txb           = tx_pending_ff ? tx_hold_ff : '0;
            snap_in       = live_ff;
            // avail reflects the count left after any pop on this tick
            rx_avail_in   = !rstat.empty && !(rx_fetched_ff && rstat.one);
            tx_pending_in = 1'b0;
            rx_fetched_in = 1'b0;
            live_in.vu_written = 1'b0;
         end
         crb_pkg::CMD_LOAD: begin
            if (req_reg_sel < crb_pkg::SEL_W'(crb_pkg::NUM_WREGS)) begin
               rd = wreg_rd;
            end else if (req_reg_sel == crb_pkg::SEL_STATUS) begin
               rd = {31'd0, rx_avail_ff};
            end else if (req_reg_sel == crb_pkg::SEL_RX) begin
               if (rx_avail_ff && !rstat.empty) begin
                  rd            = {24'd0, rstat.front};
                  rx_fetched_in = 1'b1;
               end
            end else begin
               st = crb_pkg::ST_UNKNOWN;
            end
         end
         crb_pkg::CMD_STORE: begin
            if (req_reg_sel < crb_pkg::SEL_W'(crb_pkg::NUM_WREGS)) begin
               wctrl.store = accept;
               if (req_reg_sel == crb_pkg::SEL_VUART) begin
                  live_in.vu_written = 1'b1;
                  live_in.vu_byte    = req_write_data[7:0];
               end else if (req_reg_sel == crb_pkg::SEL_NUM) begin
                  live_in.number = req_write_data;
               end else if (req_reg_sel == crb_pkg::SEL_TRACE) begin
                  live_in.trace = (req_write_data != '0);
               end else if (req_reg_sel == crb_pkg::SEL_MONITOR) begin
                  live_in.monitor = req_write_data[0];
               end
            end else if (req_reg_sel == crb_pkg::SEL_STATUS) begin
               st = crb_pkg::ST_RO;
            end else if (req_reg_sel == crb_pkg::SEL_TX) begin
               if (req_write_mask == crb_pkg::TX_BYTE_MASK) begin
                  tx_pending_in = 1'b1;
                  tx_hold_in    = req_write_data[7:0];
               end else begin
                  st = crb_pkg::ST_TX_MASK;
               end
            end else begin
               st = crb_pkg::ST_UNKNOWN;
            end
         end
         crb_pkg::CMD_PUSH: begin
            if (rstat.full) begin
               st = crb_pkg::ST_RX_FULL;
            end else begin
               rctrl.push = accept;
            end
         end
         default: begin
            st = crb_pkg::ST_OK;
         end
      endcase
      rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         rx_avail_ff   <= 1'b0;
         rx_fetched_ff <= 1'b0;
         tx_pending_ff <= 1'b0;
         tx_hold_ff    <= '0;
         live_ff       <= '0;
         snap_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            rx_avail_ff   <= rx_avail_in;
            rx_fetched_ff <= rx_fetched_in;
            tx_pending_ff <= tx_pending_in;
            tx_hold_ff    <= tx_hold_in;
            live_ff       <= live_in;
            snap_ff       <= snap_in;
         end
      end
   end

   // result word, loaded only on acceptance
   always_ff @(posedge clock) begin
      if (accept) begin
         read_data_ff <= rd;
         status_ff    <= st;
         tx_valid_ff  <= txv;
         tx_byte_ff   <= txb;
         out_ctx_ff   <= snap_in;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_read_data          = read_data_ff;
   assign rsp_status             = status_ff;
   assign rsp_tx_valid           = tx_valid_ff;
   assign rsp_tx_byte            = tx_byte_ff;
   assign rsp_vuart_valid        = out_ctx_ff.vu_written;
   assign rsp_vuart_byte         = out_ctx_ff.vu_byte;
   assign rsp_num_display        = out_ctx_ff.number;
   assign rsp_trace_enable       = out_ctx_ff.trace;
   assign rsp_num_monitor_enable = out_ctx_ff.monitor;

`ifndef SYNTH
   a_tx_on_tick: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && tx_valid_ff |-> status_ff == crb_pkg::ST_OK && read_data_ff == '0)
      else $error("transmit byte on a non-tick word");
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !req_ready)
      else $error("word taken while result stalled");
   a_tick_clears_tx: assert property (@(posedge clock) disable iff (reset)
      accept && cmd == crb_pkg::CMD_TICK |=> !tx_pending_ff && !rx_fetched_ff)
      else $error("tick left transmit or fetch pending");
   a_fetch_needs_avail: assert property (@(posedge clock) disable iff (reset)
      $rose(rx_fetched_ff) |-> rx_avail_ff && !rstat.empty)
      else $error("fetch without a byte");
`endif

endmodule

`default_nettype wire

>>> test/crb_tb_pkg.sv
// crb_tb_pkg: register file tracker and response checker for the
// configuration register block testbench; depends on crb_pkg
package crb_tb_pkg;

   import crb_pkg::*;

   class crb_scoreboard;

      typedef struct packed {
         logic [WORD_W-1:0] read_data;
         status_type        status;
         logic              tx_valid;
         logic [BYTE_W-1:0] tx_byte;
         ctx_type           snap;
      } bus_result_type;

      bus_result_type    bus_results[$];
      logic [WORD_W-1:0] wregs[NUM_WREGS];
      logic [WORD_W-1:0] staged_val[NUM_WREGS];
      bit                staged[NUM_WREGS];
      logic [BYTE_W-1:0] rx_bytes[$];
      bit                rx_avail;
      bit                rx_taken;
      bit                tx_armed;
      logic [BYTE_W-1:0] tx_hold;
      ctx_type           live_ctx;
      ctx_type           snap_ctx;
      int                errors;

      function new();
         foreach (wregs[i]) begin
            wregs[i] = '0;
            staged_val[i] = '0;
            staged[i] = 1'b0;
         end
         wregs[SEL_LED] = 32'h0000_ffff;
         wregs[SEL_SWITCH] = 32'h0000_00ff;
         wregs[SEL_SW_INTER] = 32'h0000_aaaa;
         wregs[SEL_SIMU_FLAG] = 32'hffff_ffff;
         wregs[SEL_TRACE] = 32'h0000_0001;
         wregs[SEL_MONITOR] = 32'h0000_0001;
         rx_avail = 1'b0;
         rx_taken = 1'b0;
         tx_armed = 1'b0;
         tx_hold = '0;
         live_ctx = '0;
         snap_ctx = '0;
         errors = 0;
      endfunction

      function int waiting();
         return bus_results.size();
      endfunction

      // value as it will sit in the register; some stores also reach the live context
      function logic [WORD_W-1:0] fold_store(logic [SEL_W-1:0] sel, logic [WORD_W-1:0] d);
         logic [WORD_W-1:0] v;
         v = d;
         case (sel)
            SEL_VUART: begin
               v = {24'd0, d[7:0]};
               live_ctx.vu_written = 1'b1;
               live_ctx.vu_byte = d[7:0];
            end
            SEL_NUM: live_ctx.number = d;
            SEL_SIMU_FLAG: v = '1;
            SEL_IO_SIMU: v = {d[15:0], d[31:16]};
            SEL_TRACE: begin
               v = {31'd0, (d != '0)};
               live_ctx.trace = v[0];
            end
            SEL_MONITOR: begin
               v = {31'd0, d[0]};
               live_ctx.monitor = d[0];
            end
            default: v = d;
         endcase
         return v;
      endfunction

      function void note_request(cmd_type cmd, logic [SEL_W-1:0] sel,
                                 logic [WORD_W-1:0] data, logic [WORD_W-1:0] mask);
         bus_result_type r;
         r = '0;
         r.status = ST_OK;
         case (cmd)
            CMD_TICK: begin
               if (rx_taken && rx_bytes.size() != 0) rx_bytes.delete(0);
               if (tx_armed) begin
                  r.tx_valid = 1'b1;
                  r.tx_byte = tx_hold;
               end
               snap_ctx = live_ctx;
               rx_avail = (rx_bytes.size() != 0);
               tx_armed = 1'b0;
               rx_taken = 1'b0;
               live_ctx.vu_written = 1'b0;
               for (int i = 0; i < NUM_WREGS; i++) begin
                  if (staged[i]) begin
                     wregs[i] = staged_val[i];
                     staged[i] = 1'b0;
                  end
               end
               wregs[SEL_TIMER] = wregs[SEL_TIMER] + 1;
            end
            CMD_LOAD: begin
               if (sel < NUM_WREGS) begin
                  r.read_data = wregs[sel];
               end else if (sel == SEL_STATUS) begin
                  r.read_data = {31'd0, rx_avail};
               end else if (sel == SEL_RX) begin
                  // avail reflects the last tick, so fresh pushes stay hidden
                  if (rx_avail && rx_bytes.size() != 0) begin
                     rx_taken = 1'b1;
                     r.read_data = {24'd0, rx_bytes[0]};
                  end
               end else begin
                  r.status = ST_UNKNOWN;
               end
            end
            CMD_STORE: begin
               if (sel < NUM_WREGS) begin
                  staged_val[sel] = fold_store(sel, data);
                  staged[sel] = 1'b1;
               end else if (sel == SEL_STATUS) begin
                  r.status = ST_RO;
               end else if (sel == SEL_TX) begin
                  if (mask == TX_BYTE_MASK) begin
                     tx_armed = 1'b1;
                     tx_hold = data[7:0];
                  end else begin
                     r.status = ST_TX_MASK;
                  end
               end else begin
                  r.status = ST_UNKNOWN;
               end
            end
            default: begin
               if (rx_bytes.size() >= RX_DEPTH) r.status = ST_RX_FULL;
               else rx_bytes.insert(rx_bytes.size(), data[7:0]);
            end
         endcase
         r.snap = snap_ctx;
         bus_results.insert(bus_results.size(), r);
      endfunction

      task report(string field, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
         errors++;
         $display("mismatch on %s: got %h, want %h", field, got, want);
      endtask

      task check_response(logic [WORD_W-1:0] rd, logic [2:0] st, logic txv,
                          logic [BYTE_W-1:0] txb, logic vv, logic [BYTE_W-1:0] vb,
                          logic [WORD_W-1:0] num, logic tr, logic mon);
         bus_result_type w;
         if (bus_results.size() == 0) begin
            report("unexpected word", rd, '0);
            return;
         end
         w = bus_results[0];
         bus_results.delete(0);
         if (rd !== w.read_data) report("read_data", rd, w.read_data);
         if (st !== w.status) report("status", WORD_W'(st), WORD_W'(w.status));
         if (txv !== w.tx_valid) report("tx_valid", WORD_W'(txv), WORD_W'(w.tx_valid));
         if (txb !== w.tx_byte) report("tx_byte", WORD_W'(txb), WORD_W'(w.tx_byte));
         if (vv !== w.snap.vu_written) begin
            report("vuart_valid", WORD_W'(vv), WORD_W'(w.snap.vu_written));
         end
         if (vb !== w.snap.vu_byte) report("vuart_byte", WORD_W'(vb), WORD_W'(w.snap.vu_byte));
         if (num !== w.snap.number) report("num_display", num, w.snap.number);
         if (tr !== w.snap.trace) report("trace_enable", WORD_W'(tr), WORD_W'(w.snap.trace));
         if (mon !== w.snap.monitor) begin
            report("num_monitor_enable", WORD_W'(mon), WORD_W'(w.snap.monitor));
         end
      endtask

   endclass

endpackage

>>> test/tb_top.sv
// tb_top: drives bus accesses, ticks and receive pushes into the configuration
// register block and checks every response; depends on crb_pkg and crb_tb_pkg
module tb_top;

   import crb_pkg::*;
   import crb_tb_pkg::*;

   localparam int ITEMS       = 850;
   localparam int STUCK_LIMIT = 1000;
   localparam int RSP_HOLD    = 100;
   localparam logic [SEL_W-1:0] SEL_LAST = 5'd31;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_cmd;
   logic [4:0]  req_reg_sel;
   logic [31:0] req_write_data;
   logic [31:0] req_write_mask;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_read_data;
   logic [2:0]  rsp_status;
   logic        rsp_tx_valid;
   logic [7:0]  rsp_tx_byte;
   logic        rsp_vuart_valid;
   logic [7:0]  rsp_vuart_byte;
   logic [31:0] rsp_num_display;
   logic        rsp_trace_enable;
   logic        rsp_num_monitor_enable;

   crb_scoreboard sb;
   int words_sent = 0;
   int stuck_cycles = 0;
   bit calm = 1'b0;
   bit sender_gaps = 1'b1;
   bit hold_rsp = 1'b0;

   config_register_block_with_uart dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_cmd(req_cmd),
      .req_reg_sel(req_reg_sel),
      .req_write_data(req_write_data),
      .req_write_mask(req_write_mask),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_read_data(rsp_read_data),
      .rsp_status(rsp_status),
      .rsp_tx_valid(rsp_tx_valid),
      .rsp_tx_byte(rsp_tx_byte),
      .rsp_vuart_valid(rsp_vuart_valid),
      .rsp_vuart_byte(rsp_vuart_byte),
      .rsp_num_display(rsp_num_display),
      .rsp_trace_enable(rsp_trace_enable),
      .rsp_num_monitor_enable(rsp_num_monitor_enable)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   function automatic logic [31:0] any_word();
      case ($urandom_range(0, 7))
         0: return 32'h0000_0000;
         1: return 32'hffff_ffff;
         2: return $urandom_range(0, 255);
         default: return $urandom;
      endcase
   endfunction

   // called just after a falling edge, returns just after a falling edge
   task automatic send_word(input cmd_type cmd, input logic [4:0] sel,
                            input logic [31:0] data, input logic [31:0] mask);
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_reg_sel <= sel;
      req_write_data <= data;
      req_write_mask <= mask;
      @(posedge clock);
      while (!(req_valid && req_ready)) @(posedge clock);
      sb.note_request(cmd, sel, data, mask);
      words_sent++;
      @(negedge clock);
      if (sender_gaps && !calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
   endtask

   task automatic send_tick();
      send_word(CMD_TICK, SEL_W'($urandom_range(0, 31)), any_word(), any_word());
   endtask

   task automatic random_item();
      int k;
      cmd_type cmd;
      logic [4:0] sel;
      logic [31:0] mask;
      k = $urandom_range(0, 19);
      if (k < 4) cmd = CMD_TICK;
      else if (k < 11) cmd = CMD_LOAD;
      else if (k < 17) cmd = CMD_STORE;
      else cmd = CMD_PUSH;
      sel = SEL_W'($urandom_range(0, 31));
      if (cmd == CMD_LOAD && $urandom_range(0, 3) == 0) begin
         sel = SEL_W'($urandom_range(SEL_STATUS, SEL_RX));
      end
      if (cmd == CMD_STORE && $urandom_range(0, 7) == 0) sel = SEL_TX;
      mask = ($urandom_range(0, 1) == 1) ? TX_BYTE_MASK : any_word();
      send_word(cmd, sel, any_word(), mask);
   endtask

   // push bytes, make them visible, then read them out
   task automatic rx_sequence(input int n_bytes);
      repeat (n_bytes) send_word(CMD_PUSH, SEL_W'($urandom_range(0, 31)), any_word(), any_word());
      send_tick();
      send_word(CMD_LOAD, SEL_STATUS, any_word(), any_word());
      repeat ($urandom_range(1, 3)) send_word(CMD_LOAD, SEL_RX, any_word(), any_word());
      if ($urandom_range(0, 1) == 1) send_tick();
   endtask

   task automatic store_commit();
      logic [4:0] sel;
      sel = SEL_W'($urandom_range(0, NUM_WREGS - 1));
      send_word(CMD_STORE, sel, any_word(), $urandom);
      if ($urandom_range(0, 2) == 0) send_word(CMD_STORE, sel, any_word(), $urandom);
      // the old value is still visible until the tick
      if ($urandom_range(0, 1) == 1) send_word(CMD_LOAD, sel, any_word(), any_word());
      send_tick();
      send_word(CMD_LOAD, sel, any_word(), any_word());
   endtask

   task automatic tx_sequence();
      repeat ($urandom_range(1, 2)) begin
         send_word(CMD_STORE, SEL_TX, any_word(),
                   ($urandom_range(0, 2) != 0) ? TX_BYTE_MASK : any_word());
      end
      send_tick();
   endtask

   task automatic directed_words();
      send_word(CMD_LOAD, SEL_LED, '0, '0);
      send_word(CMD_LOAD, SEL_SIMU_FLAG, '0, '0);
      send_word(CMD_LOAD, SEL_TRACE, '0, '0);
      send_word(CMD_LOAD, SEL_STATUS, '0, '0);
      send_word(CMD_LOAD, SEL_RX, '0, '0);
      send_word(CMD_STORE, SEL_IO_SIMU, 32'h1234_5678, '1);
      send_word(CMD_STORE, SEL_SIMU_FLAG, '0, '0);
      send_word(CMD_STORE, SEL_TRACE, 32'h8000_0000, '1);
      send_word(CMD_STORE, SEL_MONITOR, 32'hffff_fffe, '1);
      send_word(CMD_STORE, SEL_VUART, 32'hffff_ffa5, '1);
      send_word(CMD_STORE, SEL_NUM, 32'hffff_ffff, '1);
      send_word(CMD_STORE, SEL_NUM, 32'h0000_0000, '0);
      send_word(CMD_STORE, SEL_STATUS, '1, '1);
      send_word(CMD_STORE, SEL_TX, 32'hffff_ff3c, TX_BYTE_MASK);
      send_word(CMD_STORE, SEL_TX, 32'h0000_00c3, '1);
      send_word(CMD_STORE, SEL_RX, '1, '1);
      send_word(CMD_STORE, SEL_LAST, '1, '1);
      send_word(CMD_LOAD, SEL_TX, '0, '0);
      send_word(CMD_LOAD, SEL_LAST, '0, '0);
      send_word(CMD_PUSH, '0, 32'hffff_ffff, '0);
      send_word(CMD_PUSH, '1, 32'h0000_0000, '1);
      send_word(CMD_LOAD, SEL_RX, '0, '0);
      send_word(CMD_TICK, '0, '0, '0);
      send_word(CMD_LOAD, SEL_STATUS, '0, '0);
      send_word(CMD_LOAD, SEL_RX, '0, '0);
      send_word(CMD_LOAD, SEL_RX, '0, '0);
      send_word(CMD_TICK, '1, '1, '1);
      send_word(CMD_LOAD, SEL_IO_SIMU, '0, '0);
      send_word(CMD_LOAD, SEL_TIMER, '0, '0);
      send_word(CMD_TICK, '0, '0, '0);
   endtask

   initial begin
      int pick;
      bit squeezed;
      bit drained;
      sb = new();
      squeezed = 1'b0;
      drained = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd = '0;
      req_reg_sel = '0;
      req_write_data = '0;
      req_write_mask = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      directed_words();
      while (words_sent < ITEMS) begin
         if (words_sent >= ITEMS - 150) calm = 1'b1;
         if (!squeezed && words_sent >= 300) begin
            // responses held back while words keep coming, so the input stalls
            squeezed = 1'b1;
            hold_rsp = 1'b1;
            sender_gaps = 1'b0;
            repeat (12) random_item();
            sender_gaps = 1'b1;
         end else if (!drained && words_sent >= 550) begin
            drained = 1'b1;
            req_valid <= 1'b0;
            while (sb.waiting() != 0) @(negedge clock);
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 5) rx_sequence($urandom_range(14, 20));
            else if (pick < 18) rx_sequence($urandom_range(1, 3));
            else if (pick < 28) store_commit();
            else if (pick < 33) tx_sequence();
            else random_item();
         end
      end
      req_valid <= 1'b0;
      while (sb.waiting() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.errors == 0) begin
         $display("PASS config_register_block_with_uart");
      end else begin
         $display("FAIL config_register_block_with_uart");
      end
      $finish;
   end

   initial begin
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD) @(negedge clock);
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_response(rsp_read_data, rsp_status, rsp_tx_valid, rsp_tx_byte,
                           rsp_vuart_valid, rsp_vuart_byte, rsp_num_display,
                           rsp_trace_enable, rsp_num_monitor_enable);
      end
   end

   // no word moving on either side for too long means the block has hung
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) stuck_cycles <= 0;
      else stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("FAIL config_register_block_with_uart");
         $finish;
      end
   end

endmodule

>>> filelist.f
design/crb_pkg.sv
design/crb_rxq.sv
design/crb_wregs.sv
design/config_register_block_with_uart.sv
test/crb_tb_pkg.sv
test/tb_top.sv
